### design/ttli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttli_pkg: shared types and constants for the transposition table
// Field widths, table geometry, the slot layout and the request structs
// passed between the table store and the update logic.
// ----------------------------------------------------------------------------
package ttli_pkg;

  // Table geometry. The slot index is the low bits of the key, so the
  // entry count must be a power of two.
  localparam int ENTRIES   = 4096;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int LOAD_W    = $clog2(ENTRIES + 1);

  // Word field widths.
  localparam int KEY_W     = 64;
  localparam int TAG_SHIFT = 16;
  localparam int TAG_W     = KEY_W - TAG_SHIFT;
  localparam int MOVE_W    = 16;
  localparam int DEPTH_W   = 8;
  localparam int EVAL_W    = 16;
  localparam int KIND_W    = 2;

  // Operation codes.
  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_INSERT = 1'b1
  } mode_t;

  // One table slot; a slot is empty when its move is zero.
  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic [MOVE_W-1:0]         move;
    logic [DEPTH_W-1:0]        depth;
    logic signed [EVAL_W-1:0]  eval;
    logic [KIND_W-1:0]         kind;
  } entry_t;

  // An accepted word after the input register.
  typedef struct packed {
    mode_t                     mode;
    logic [IDX_W-1:0]          idx;
    logic [TAG_W-1:0]          tag;
    logic [DEPTH_W-1:0]        depth;
    logic [MOVE_W-1:0]         move;
    logic signed [EVAL_W-1:0]  eval;
    logic [KIND_W-1:0]         kind;
  } item_t;

  // Write request into the table.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    entry_t            data;
  } wr_req_t;

endpackage
`default_nettype wire

### design/ttli_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttli_store: slot memory with clearing sweep
// One write port and one registered read port. After reset every slot is
// zeroed, one per cycle, while busy is held high.
// ----------------------------------------------------------------------------
module ttli_store
  import ttli_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  output logic                  busy,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output entry_t                rd_data,
  input  wire wr_req_t          wr
);

  entry_t           mem [ENTRIES];
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  // Clearing sweep: walks every slot once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing;

  // Write port, shared by the sweep and the update logic.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

`ifndef SYNTHESIS
  // The update logic never writes while the sweep owns the port.
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !clearing) else $error("table write during clearing sweep");

  // The sweep only ends after the last slot.
  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_idx) == IDX_W'(ENTRIES - 1))
    else $error("clearing sweep ended early");
`endif

endmodule
`default_nettype wire

### design/ttli_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttli_update: slot compare, load count and write-back
// Compares the addressed slot with the word, forms the result, keeps the
// occupied-slot count and issues the write for an insert.
// ----------------------------------------------------------------------------
module ttli_update
  import ttli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s1_valid,
  input  wire item_t             s1,
  input  wire entry_t            rd_data,
  output wr_req_t                wr,
  output logic                   done,
  output logic                   slot_occupied,
  output logic                   tag_match,
  output logic                   deep_match,
  output logic [MOVE_W-1:0]      stored_move,
  output logic [DEPTH_W-1:0]     stored_depth,
  output logic [LOAD_W-1:0]      load_count
);

  logic             fwd_en;
  logic [IDX_W-1:0] fwd_idx;
  entry_t           fwd_data;
  entry_t           old_entry;
  logic             occ;
  logic             tmatch;
  logic             dmatch;
  logic             is_insert;
  logic             new_occ;
  logic [LOAD_W-1:0] count;
  logic [LOAD_W-1:0] count_next;

  // The read for this word was taken at the edge of the previous write;
  // a write to the same slot then is forwarded instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else begin
      fwd_en <= wr.en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx  <= wr.idx;
    fwd_data <= wr.data;
  end

  assign old_entry = (fwd_en && (fwd_idx == s1.idx)) ? fwd_data : rd_data;

  // Slot compare.
  assign occ    = (old_entry.move != '0);
  assign tmatch = occ && (old_entry.tag == s1.tag);
  assign dmatch = tmatch && (old_entry.depth >= s1.depth);

  // Occupied-slot count follows empty/occupied transitions of inserts.
  assign is_insert = s1_valid && (s1.mode == MODE_INSERT);
  assign new_occ   = (s1.move != '0);

  always_comb begin
    count_next = count;
    if (is_insert) begin
      if (!occ && new_occ) begin
        count_next = count + 1'b1;
      end else if (occ && !new_occ && (count != '0)) begin
        count_next = count - 1'b1;
      end
    end
  end

  // Write-back of an insert overwrites the whole slot.
  always_comb begin
    wr.en         = is_insert;
    wr.idx        = s1.idx;
    wr.data.tag   = s1.tag;
    wr.data.move  = s1.move;
    wr.data.depth = s1.depth;
    wr.data.eval  = s1.eval;
    wr.data.kind  = s1.kind;
  end

  // Control state: count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= s1_valid;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      slot_occupied <= occ;
      tag_match     <= tmatch;
      deep_match    <= dmatch;
      stored_move   <= old_entry.move;
      stored_depth  <= old_entry.depth;
      load_count    <= count_next;
    end
  end

`ifndef SYNTHESIS
  // Match flags are nested: deep implies tag implies occupied.
  a_flag_nesting: assert property (@(posedge clk) disable iff (rst)
    done |-> ((!deep_match || tag_match) && (!tag_match || slot_occupied)))
    else $error("result flags not nested");

  // One word moves the count by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> ((count == $past(count)) ||
                     (count == LOAD_W'($past(count) + 1'b1)) ||
                     (LOAD_W'(count + 1'b1) == $past(count))))
    else $error("load count jumped");
`endif

endmodule
`default_nettype wire

### design/transposition_table_lookup_insert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transposition_table_lookup_insert: direct-mapped position table
// Lookup or insert by a 64-bit position key, one word per cycle unless busy.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at a rising edge with start high and busy low. mode
//   selects a lookup or an insert; the low key bits pick the slot, the
//   upper 48 bits are the tag. Each word gives exactly one result word,
//   shown for one cycle with done high; the receiver cannot stall it.
//   The word passes the input register, then the result register, whose
//   strobe is done. A new word can be taken every cycle while busy is low;
//   the slot memory is read at the accepting edge and written at the next
//   edge, with the write forwarded to a following word on the same slot.
//   An insert reports the slot's old contents, then overwrites the slot.
//   load_count is the number of occupied slots after the word.
//   Reset: after rst falls, busy stays high while every slot is cleared
//   to empty, one slot per cycle; the load count and the result strobe
//   are cleared at once.
// ----------------------------------------------------------------------------
module transposition_table_lookup_insert
  import ttli_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      mode,
  input  wire logic [KEY_W-1:0]          position_key,
  input  wire logic [DEPTH_W-1:0]        search_depth,
  input  wire logic [MOVE_W-1:0]         best_move,
  input  wire logic signed [EVAL_W-1:0]  evaluation,
  input  wire logic [KIND_W-1:0]         score_kind,
  output logic                           done,
  output logic                           slot_occupied,
  output logic                           tag_match,
  output logic                           deep_match,
  output logic [MOVE_W-1:0]              stored_move,
  output logic [DEPTH_W-1:0]             stored_depth,
  output logic [LOAD_W-1:0]              load_count
);

  logic             accept;
  logic [IDX_W-1:0] in_idx;
  logic             s1_valid;
  item_t            s1;
  entry_t           rd_data;
  wr_req_t          wr;

  assign accept = start && !busy;
  assign in_idx = position_key[IDX_W-1:0];

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.mode  <= mode_t'(mode);
      s1.idx   <= in_idx;
      s1.tag   <= position_key[KEY_W-1:TAG_SHIFT];
      s1.depth <= search_depth;
      s1.move  <= best_move;
      s1.eval  <= evaluation;
      s1.kind  <= score_kind;
    end
  end

  // Slot memory.
  ttli_store u_store (
    .clk     (clk),
    .rst     (rst),
    .busy    (busy),
    .rd_en   (accept),
    .rd_idx  (in_idx),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // Compare, count and write-back.
  ttli_update u_update (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .rd_data       (rd_data),
    .wr            (wr),
    .done          (done),
    .slot_occupied (slot_occupied),
    .tag_match     (tag_match),
    .deep_match    (deep_match),
    .stored_move   (stored_move),
    .stored_depth  (stored_depth),
    .load_count    (load_count)
  );

`ifndef SYNTHESIS
  // Every accepted word gives its result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done) else $error("accepted word gave no result");

  // No result without an accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && $past(!rst, 2)) |-> $past(accept, 2))
    else $error("result without accepted word");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for transposition_table_lookup_insert
// Feeds lookup and insert words through the start/busy handshake with random
// idle gaps. A behavioral copy of the table predicts every result word, and
// the monitor compares each done word in order against those predictions.
// ----------------------------------------------------------------------------
module testbench;
  import ttli_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 1280;
  localparam int POOL_DEPTH   = 256;

  // One request word as driven on the input ports.
  typedef struct packed {
    mode_t                     mode;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic [MOVE_W-1:0]         move;
    logic signed [EVAL_W-1:0]  eval;
    logic [KIND_W-1:0]         kind;
  } probe_word_t;

  // One predicted result word.
  typedef struct packed {
    logic                  occupied;
    logic                  tag_hit;
    logic                  deep_hit;
    logic [MOVE_W-1:0]     move;
    logic [DEPTH_W-1:0]    depth;
    logic [LOAD_W-1:0]     load;
  } probe_report_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      mode = 1'b0;
  logic [KEY_W-1:0]          position_key = '0;
  logic [DEPTH_W-1:0]        search_depth = '0;
  logic [MOVE_W-1:0]         best_move = '0;
  logic signed [EVAL_W-1:0]  evaluation = '0;
  logic [KIND_W-1:0]         score_kind = '0;
  logic                      done;
  logic                      slot_occupied;
  logic                      tag_match;
  logic                      deep_match;
  logic [MOVE_W-1:0]         stored_move;
  logic [DEPTH_W-1:0]        stored_depth;
  logic [LOAD_W-1:0]         load_count;

  transposition_table_lookup_insert DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .position_key  (position_key),
    .search_depth  (search_depth),
    .best_move     (best_move),
    .evaluation    (evaluation),
    .score_kind    (score_kind),
    .done          (done),
    .slot_occupied (slot_occupied),
    .tag_match     (tag_match),
    .deep_match    (deep_match),
    .stored_move   (stored_move),
    .stored_depth  (stored_depth),
    .load_count    (load_count)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the table; bit arrays start out all zero, which is the
  // empty state after reset.
  bit [TAG_W-1:0]    table_tag   [ENTRIES];
  bit [MOVE_W-1:0]   table_move  [ENTRIES];
  bit [DEPTH_W-1:0]  table_depth [ENTRIES];
  int unsigned       occupied_slots = 0;

  probe_word_t       pending_words [$];
  probe_report_t     expected_reports [$];
  logic [KEY_W-1:0]  key_pool [$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  idle_left = 0;
  int  steady_left = 0;
  bit  word_taken = 1'b0;

  // Report the slot as it was before the word, then apply an insert.
  function automatic probe_report_t probe_table(probe_word_t w);
    int unsigned       slot;
    logic [TAG_W-1:0]  tag;
    probe_report_t     r;
    slot = int'(w.key % KEY_W'(ENTRIES));
    tag = w.key[KEY_W-1:TAG_SHIFT];
    r.occupied = table_move[slot] != '0;
    r.tag_hit = r.occupied && (table_tag[slot] == tag);
    r.deep_hit = r.tag_hit && (table_depth[slot] >= w.depth);
    r.move = table_move[slot];
    r.depth = table_depth[slot];
    if (w.mode == MODE_INSERT) begin
      // A zero move empties the slot; the count follows the change.
      if (!r.occupied && w.move != '0) begin
        occupied_slots++;
      end else if (r.occupied && w.move == '0 && occupied_slots > 0) begin
        occupied_slots--;
      end
      table_tag[slot] = tag;
      table_move[slot] = w.move;
      table_depth[slot] = w.depth;
    end
    r.load = LOAD_W'(occupied_slots);
    return r;
  endfunction

  function automatic void queue_word(mode_t m, logic [KEY_W-1:0] key,
                                     logic [DEPTH_W-1:0] depth,
                                     logic [MOVE_W-1:0] move_code,
                                     logic signed [EVAL_W-1:0] score,
                                     logic [KIND_W-1:0] kind);
    probe_word_t w;
    w.mode = m;
    w.key = key;
    w.depth = depth;
    w.move = move_code;
    w.eval = score;
    w.kind = kind;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Idle gap after an accepted word: mostly none or short, a few long, and
  // now and then a long stretch with no gaps at all.
  function automatic int next_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 8) begin
      steady_left = $urandom_range(40, 160);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 900) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic void check_field(string field_name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h",
               $time, field_name, want, got);
      error_count++;
    end
  endfunction

  // Driver: presents the oldest pending word at the falling edge and keeps
  // it steady until the handshake takes it; idle cycles carry random data.
  always @(negedge clk) begin : driver
    probe_word_t  w;
    logic [127:0] noise;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (word_taken) idle_left = next_gap();
      if (idle_left > 0 || pending_words.size() == 0) begin
        if (idle_left > 0) idle_left--;
        noise = {$urandom, $urandom, $urandom, $urandom};
        w = noise[$bits(probe_word_t)-1:0];
        start <= 1'b0;
      end else begin
        w = pending_words[0];
        start <= 1'b1;
      end
      mode <= w.mode;
      position_key <= w.key;
      search_depth <= w.depth;
      best_move <= w.move;
      evaluation <= w.eval;
      score_kind <= w.kind;
    end
  end

  // Monitor: checks the result word shown this cycle, then records the
  // prediction for a word accepted at this edge.
  always @(posedge clk) begin : monitor
    probe_report_t want;
    if (!rst && done) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result word with none expected", $time);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("slot_occupied", want.occupied, slot_occupied);
        check_field("tag_match", want.tag_hit, tag_match);
        check_field("deep_match", want.deep_hit, deep_match);
        check_field("stored_move", want.move, stored_move);
        check_field("stored_depth", want.depth, stored_depth);
        check_field("load_count", want.load, load_count);
      end
    end
    word_taken = !rst && start && !busy;
    if (word_taken) begin
      expected_reports.insert(expected_reports.size(),
                              probe_table(pending_words[0]));
      void'(pending_words.pop_front());
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  full_key;
    logic [MOVE_W-1:0] move_code;
    logic [DEPTH_W-1:0] depth;
    mode_t             m;
    int                pick;

    full_key = '1;

    // Directed words: empty probes, extreme fields, tag and depth misses,
    // zero-move inserts emptying a slot, and insert then lookup of one slot.
    queue_word(MODE_LOOKUP, '0, '0, '0, '0, 2'd0);
    queue_word(MODE_LOOKUP, full_key, 8'hFF, 16'hFFFF, 16'sh7FFF, 2'd3);
    queue_word(MODE_INSERT, full_key, 8'hFF, 16'hFFFF, -16'sd32768, 2'd3);
    queue_word(MODE_LOOKUP, full_key, 8'hFF, '0, '0, 2'd0);
    queue_word(MODE_LOOKUP, full_key ^ (64'd1 << 63), 8'h00, '0, '0, 2'd0);
    queue_word(MODE_LOOKUP, full_key ^ (64'd1 << TAG_SHIFT), 8'h00, '0, '0, 2'd0);
    queue_word(MODE_INSERT, 64'h0000_1234_5678_0001, 8'd10, 16'h0001, 16'sh7FFF, 2'd0);
    queue_word(MODE_LOOKUP, 64'h0000_1234_5678_0001, 8'd11, '0, '0, 2'd0);
    queue_word(MODE_LOOKUP, 64'h0000_1234_5678_0001, 8'd10, '0, '0, 2'd0);
    queue_word(MODE_INSERT, 64'h8765_4321_0000_0001, 8'd0, 16'h8000, 16'sd0, 2'd1);
    queue_word(MODE_LOOKUP, 64'h8765_4321_0000_0001, 8'd0, '0, '0, 2'd0);
    queue_word(MODE_INSERT, full_key, 8'd7, 16'h0000, 16'sd5, 2'd2);
    queue_word(MODE_LOOKUP, full_key, 8'd0, '0, '0, 2'd0);
    queue_word(MODE_INSERT, '0, 8'd3, 16'h0000, 16'sd1, 2'd1);
    queue_word(MODE_INSERT, '0, 8'd0, 16'h00FF, -16'sd1, 2'd0);
    queue_word(MODE_INSERT, '0, 8'hFF, 16'hFF00, 16'sd100, 2'd2);
    queue_word(MODE_LOOKUP, '0, 8'hFF, '0, '0, 2'd0);
    queue_word(MODE_LOOKUP, 64'h0000_0000_0001_0000, 8'd0, '0, '0, 2'd0);
    queue_word(MODE_INSERT, 64'hABCD_EF01_2345_6002, 8'd128, 16'h5A5A, 16'sd0, 2'd2);
    queue_word(MODE_LOOKUP, 64'hABCD_EF01_2345_6002, 8'd128, '0, '0, 2'd0);
    queue_word(MODE_LOOKUP, 64'hABCD_EF01_2345_6002, 8'd129, '0, '0, 2'd0);
    queue_word(MODE_INSERT, 64'hABCD_EF01_2345_6002, 8'd1, 16'h0000, 16'sd0, 2'd0);

    // Random words, biased toward keys already stored so that tag and depth
    // hits, overwrites and evictions happen often.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      key = {$urandom, $urandom};
      if (pick < 40 && key_pool.size() != 0) begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (pick < 55 && key_pool.size() != 0) begin
        // Same slot, different tag.
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if ($urandom_range(0, 1) == 0) begin
          key = key ^ (64'd1 << $urandom_range(TAG_SHIFT, KEY_W - 1));
        end else begin
          key[KEY_W-1:TAG_SHIFT] = TAG_W'({$urandom, $urandom});
        end
      end else if (pick < 70) begin
        // Crowd a handful of slots.
        key[IDX_W-1:0] = IDX_W'($urandom_range(0, 15));
      end

      pick = $urandom_range(0, 99);
      if (pick < 12) move_code = '0;
      else if (pick < 17) move_code = '1;
      else move_code = MOVE_W'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 10) depth = '0;
      else if (pick < 20) depth = '1;
      else depth = DEPTH_W'($urandom);

      m = ($urandom_range(0, 1) == 1) ? MODE_INSERT : MODE_LOOKUP;
      if (m == MODE_INSERT) begin
        key_pool.insert(key_pool.size(), key);
        if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
      queue_word(m, key, depth, move_code, EVAL_W'($urandom),
                 KIND_W'($urandom_range(0, 3)));
    end

    // Hold reset, then release it; the block then clears its table while busy.
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### transposition_table_lookup_insert.f
design/ttli_pkg.sv
design/ttli_store.sv
design/ttli_update.sv
design/transposition_table_lookup_insert.sv
tb/testbench.sv
